// ===== sv/apd_pkg.sv =====
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types and constants for the audio presence detector.
// ----------------------------------------------------------------------------
package apd_pkg;

    // default sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_THR  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOUD_THR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_TOL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_DEB    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_DEB     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STUCK_DEB  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 3'd6;

    // register reset values
    localparam logic [11:0] RST_QUIET_THR  = 12'd10;
    localparam logic [11:0] RST_LOUD_THR   = 12'd20;
    localparam logic [11:0] RST_CHANGE_TOL = 12'd4;
    localparam logic [7:0]  RST_OFF_DEB    = 8'd10;
    localparam logic [7:0]  RST_ON_DEB     = 8'd3;
    localparam logic [7:0]  RST_STUCK_DEB  = 8'd5;
    localparam logic [15:0] RST_WINDOW_LEN = 16'd256;

    // window classes
    typedef enum logic [1:0] {
        CLS_LOUD_STUCK  = 2'd0,
        CLS_LOUD_MOVING = 2'd1,
        CLS_QUIET       = 2'd2,
        CLS_DEADBAND    = 2'd3
    } t_class;

    // configuration register set
    typedef struct packed {
        logic [11:0] quiet_thr;
        logic [11:0] loud_thr;
        logic [11:0] change_tol;
        logic [7:0]  off_deb;
        logic [7:0]  on_deb;
        logic [7:0]  stuck_deb;
        logic [15:0] window_len;
    } t_cfg;

    // verdict for one closed window
    typedef struct packed {
        logic   level;
        t_class cls;
    } t_verdict;

endpackage

// ===== sv/apd_window.sv =====
// ----------------------------------------------------------------------------
// apd_window
// Input register, running peak of both channels and window pair count.
// ----------------------------------------------------------------------------
module apd_window #(
    parameter int SAMPLE_BITS = apd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_a,
    input  logic [SAMPLE_BITS-1:0] i_sample_b,
    input  logic [15:0]            i_window_len,
    input  logic                   i_slot_free,
    output logic                   o_close_valid,
    output logic [SAMPLE_BITS-1:0] o_close_peak
);
    import apd_pkg::*;

    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_a;
    logic [SAMPLE_BITS-1:0] r_s1_b;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [15:0]            r_count;

    logic [SAMPLE_BITS-1:0] s_max;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [16:0]            n_count;
    logic                   s_closes;
    logic                   s_fire;

    // peak and count for the held item
    always_comb begin
        s_max    = (r_s1_a > r_s1_b) ? r_s1_a : r_s1_b;
        n_peak   = (s_max > r_peak) ? s_max : r_peak;
        n_count  = {1'b0, r_count} + 17'd1;
        s_closes = n_count >= {1'b0, i_window_len};
        s_fire   = r_s1_valid && (!s_closes || i_slot_free);
    end

    assign o_in_stall    = r_s1_valid && !s_fire;
    assign o_close_valid = r_s1_valid && s_closes && i_slot_free;
    assign o_close_peak  = n_peak;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_a <= i_sample_a;
            r_s1_b <= i_sample_b;
        end
    end

    // peak hold and pair count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_count <= '0;
        end else if (s_fire) begin
            if (s_closes) begin
                r_peak  <= '0;
                r_count <= '0;
            end else begin
                r_peak  <= n_peak;
                r_count <= n_count[15:0];
            end
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("stall raised with no held item");

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_close_valid |=> (r_count == 16'd0 && r_peak == '0))
        else $error("window state not cleared after close");

endmodule

// ===== sv/apd_debounce.sv =====
// ----------------------------------------------------------------------------
// apd_debounce
// Window classification, debounce counters and presence level.
// ----------------------------------------------------------------------------
module apd_debounce #(
    parameter int SAMPLE_BITS = apd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  apd_pkg::t_cfg          i_cfg,
    input  logic                   i_close_valid,
    input  logic [SAMPLE_BITS-1:0] i_close_peak,
    output apd_pkg::t_verdict      o_verdict
);
    import apd_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

    logic [SAMPLE_BITS-1:0] r_prev_peak;
    logic [7:0]             r_stuck_cnt;
    logic [7:0]             r_off_cnt;
    logic [7:0]             r_on_cnt;
    logic                   r_level;

    logic [SAMPLE_BITS-1:0] n_prev_peak;
    logic [7:0]             n_stuck_cnt;
    logic [7:0]             n_off_cnt;
    logic [7:0]             n_on_cnt;
    logic                   n_level;

    logic [CMP_W-1:0] s_peak;
    logic [CMP_W-1:0] s_prev;
    logic [CMP_W-1:0] s_diff;
    logic             s_stuck;
    logic             s_loud;
    logic             s_quiet;
    logic [7:0]       s_stuck_dec;
    logic [7:0]       s_off_dec;
    logic [7:0]       s_on_dec;
    t_class           s_cls;

    // change magnitude and thresholds
    always_comb begin
        s_peak  = CMP_W'(i_close_peak);
        s_prev  = CMP_W'(r_prev_peak);
        s_diff  = (s_peak > s_prev) ? (s_peak - s_prev) : (s_prev - s_peak);
        s_stuck = s_diff < CMP_W'(i_cfg.change_tol);
        s_loud  = s_peak > CMP_W'(i_cfg.loud_thr);
        s_quiet = s_peak < CMP_W'(i_cfg.quiet_thr);
        s_stuck_dec = r_stuck_cnt - 8'd1;
        s_off_dec   = r_off_cnt - 8'd1;
        s_on_dec    = r_on_cnt - 8'd1;
    end

    // class and counter updates
    always_comb begin
        n_prev_peak = i_close_peak;
        n_stuck_cnt = r_stuck_cnt;
        n_off_cnt   = r_off_cnt;
        n_on_cnt    = r_on_cnt;
        n_level     = r_level;
        priority if (s_loud && s_stuck) begin
            s_cls     = CLS_LOUD_STUCK;
            n_off_cnt = i_cfg.off_deb;
            n_on_cnt  = i_cfg.on_deb;
            if (s_stuck_dec == 8'd0) begin
                n_level     = 1'b0;
                n_stuck_cnt = i_cfg.stuck_deb;
            end else begin
                n_stuck_cnt = s_stuck_dec;
            end
        end else if (s_loud) begin
            s_cls       = CLS_LOUD_MOVING;
            n_stuck_cnt = i_cfg.stuck_deb;
            n_off_cnt   = i_cfg.off_deb;
            if (s_on_dec == 8'd0) begin
                n_level  = 1'b1;
                n_on_cnt = i_cfg.on_deb;
            end else begin
                n_on_cnt = s_on_dec;
            end
        end else if (s_quiet) begin
            s_cls       = CLS_QUIET;
            n_stuck_cnt = i_cfg.stuck_deb;
            n_on_cnt    = i_cfg.on_deb;
            if (s_off_dec == 8'd0) begin
                n_level   = 1'b0;
                n_off_cnt = i_cfg.off_deb;
            end else begin
                n_off_cnt = s_off_dec;
            end
        end else begin
            s_cls       = CLS_DEADBAND;
            n_stuck_cnt = i_cfg.stuck_deb;
        end
    end

    assign o_verdict.level = n_level;
    assign o_verdict.cls   = s_cls;

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_peak <= '0;
            r_stuck_cnt <= RST_STUCK_DEB;
            r_off_cnt   <= RST_OFF_DEB;
            r_on_cnt    <= RST_ON_DEB;
            r_level     <= 1'b0;
        end else if (i_close_valid) begin
            r_prev_peak <= n_prev_peak;
            r_stuck_cnt <= n_stuck_cnt;
            r_off_cnt   <= n_off_cnt;
            r_on_cnt    <= n_on_cnt;
            r_level     <= n_level;
        end
    end

    a_level_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_level) |-> $past(i_close_valid && s_cls == CLS_LOUD_MOVING))
        else $error("level rose without a loud changing window");

endmodule

// ===== sv/audio_presence_detector.sv =====
// ----------------------------------------------------------------------------
// audio_presence_detector
// Peak-hold sound presence detector over two converter channels.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_sample_a/b   | item in
//  out     | o_out_valid, i_out_stall, o_sound_present,
//          | o_window_peak, o_window_class          | item out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | write
//
//  one sample pair per cycle while o_in_stall is low; the pair that closes a
//  window passes the input register, then the result register, to the output
//  synchronous active-low reset; valid, state and configuration registers
//  return to their default values; the result register holds while stalled;
//  pairs that do not close a window keep flowing, a closing pair waits in the
//  input register for a free slot; the configuration port is always ready
// ----------------------------------------------------------------------------
module audio_presence_detector #(
    parameter int SAMPLE_BITS = apd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [SAMPLE_BITS-1:0]         i_sample_a,
    input  logic [SAMPLE_BITS-1:0]         i_sample_b,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_sound_present,
    output logic [SAMPLE_BITS-1:0]         o_window_peak,
    output logic [1:0]                     o_window_class,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [apd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apd_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_out_valid;
    logic                   r_out_level;
    logic [SAMPLE_BITS-1:0] r_out_peak;
    t_class                 r_out_class;

    logic                   s_slot_free;
    logic                   s_close_valid;
    logic [SAMPLE_BITS-1:0] s_close_peak;
    t_verdict               s_verdict;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_thr  <= RST_QUIET_THR;
            r_cfg.loud_thr   <= RST_LOUD_THR;
            r_cfg.change_tol <= RST_CHANGE_TOL;
            r_cfg.off_deb    <= RST_OFF_DEB;
            r_cfg.on_deb     <= RST_ON_DEB;
            r_cfg.stuck_deb  <= RST_STUCK_DEB;
            r_cfg.window_len <= RST_WINDOW_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_QUIET_THR:  r_cfg.quiet_thr  <= i_cfg_data[11:0];
                REG_LOUD_THR:   r_cfg.loud_thr   <= i_cfg_data[11:0];
                REG_CHANGE_TOL: r_cfg.change_tol <= i_cfg_data[11:0];
                REG_OFF_DEB:    r_cfg.off_deb    <= i_cfg_data[7:0];
                REG_ON_DEB:     r_cfg.on_deb     <= i_cfg_data[7:0];
                REG_STUCK_DEB:  r_cfg.stuck_deb  <= i_cfg_data[7:0];
                REG_WINDOW_LEN: r_cfg.window_len <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign s_slot_free = !r_out_valid || !i_out_stall;

    // peak hold window
    apd_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_window_len  (r_cfg.window_len),
        .i_slot_free   (s_slot_free),
        .o_close_valid (s_close_valid),
        .o_close_peak  (s_close_peak)
    );

    // classification and debounce
    apd_debounce #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_close_valid (s_close_valid),
        .i_close_peak  (s_close_peak),
        .o_verdict     (s_verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_close_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_close_valid) begin
            r_out_level <= s_verdict.level;
            r_out_peak  <= s_close_peak;
            r_out_class <= s_verdict.cls;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sound_present = r_out_level;
    assign o_window_peak   = r_out_peak;
    assign o_window_class  = r_out_class;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !s_close_valid)
        else $error("closed window would overwrite a pending item");

    a_close_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_close_valid |=> r_out_valid)
        else $error("closed window not presented");

endmodule

// ===== test/apd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apd_checker
// Watches the sample, result and register channels of the presence detector.
// It keeps its own copy of the register set and the window state, works out
// the report for every window that closes, and compares each report that
// leaves the block with the oldest one it expects.
// ----------------------------------------------------------------------------
module apd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [11:0]                     i_sample_a,
    input  logic [11:0]                     i_sample_b,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_sound_present,
    input  logic [11:0]                     i_window_peak,
    input  logic [1:0]                      i_window_class,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [apd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_windows_checked
);
    import apd_pkg::*;

    typedef struct packed {
        logic        level;
        logic [11:0] peak;
        t_class      cls;
    } t_report;

    // mirrored registers and window state
    t_cfg        regs;
    logic [11:0] run_peak;
    logic [11:0] last_peak;
    logic [16:0] pair_count;
    logic [7:0]  stuck_cnt;
    logic [7:0]  off_cnt;
    logic [7:0]  on_cnt;
    logic        level;

    t_report     expected_reports[$];
    int          fails = 0;
    int          windows = 0;

    assign o_fail_count      = fails;
    assign o_windows_checked = windows;

    task automatic reset_state();
        regs.quiet_thr  = RST_QUIET_THR;
        regs.loud_thr   = RST_LOUD_THR;
        regs.change_tol = RST_CHANGE_TOL;
        regs.off_deb    = RST_OFF_DEB;
        regs.on_deb     = RST_ON_DEB;
        regs.stuck_deb  = RST_STUCK_DEB;
        regs.window_len = RST_WINDOW_LEN;
        run_peak   = '0;
        last_peak  = '0;
        pair_count = '0;
        stuck_cnt  = RST_STUCK_DEB;
        off_cnt    = RST_OFF_DEB;
        on_cnt     = RST_ON_DEB;
        level      = 1'b0;
        expected_reports.delete();
    endtask

    // register write, data masked to the register width
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_QUIET_THR:  regs.quiet_thr  = data[11:0];
            REG_LOUD_THR:   regs.loud_thr   = data[11:0];
            REG_CHANGE_TOL: regs.change_tol = data[11:0];
            REG_OFF_DEB:    regs.off_deb    = data[7:0];
            REG_ON_DEB:     regs.on_deb     = data[7:0];
            REG_STUCK_DEB:  regs.stuck_deb  = data[7:0];
            REG_WINDOW_LEN: regs.window_len = data;
            default: ;  // index past the register list does nothing
        endcase
    endtask

    // peak hold, and on the closing pair the class and debounce update
    task automatic take_pair(input logic [11:0] a, input logic [11:0] b);
        logic [11:0] louder;
        logic [11:0] peak;
        logic [11:0] delta;
        logic        stuck;
        t_report     rpt;
        louder = (a > b) ? a : b;
        if (louder > run_peak) run_peak = louder;
        pair_count = pair_count + 17'd1;
        if (pair_count >= {1'b0, regs.window_len}) begin
            peak       = run_peak;
            run_peak   = '0;
            pair_count = '0;
            delta      = (peak > last_peak) ? peak - last_peak : last_peak - peak;
            stuck      = delta < regs.change_tol;
            if (peak > regs.loud_thr && stuck) begin
                rpt.cls   = CLS_LOUD_STUCK;
                off_cnt   = regs.off_deb;
                on_cnt    = regs.on_deb;
                stuck_cnt = stuck_cnt - 8'd1;
                if (stuck_cnt == 8'd0) begin
                    level     = 1'b0;
                    stuck_cnt = regs.stuck_deb;
                end
            end else if (peak > regs.loud_thr) begin
                rpt.cls   = CLS_LOUD_MOVING;
                stuck_cnt = regs.stuck_deb;
                off_cnt   = regs.off_deb;
                on_cnt    = on_cnt - 8'd1;
                if (on_cnt == 8'd0) begin
                    level  = 1'b1;
                    on_cnt = regs.on_deb;
                end
            end else if (peak < regs.quiet_thr) begin
                rpt.cls   = CLS_QUIET;
                stuck_cnt = regs.stuck_deb;
                on_cnt    = regs.on_deb;
                off_cnt   = off_cnt - 8'd1;
                if (off_cnt == 8'd0) begin
                    level   = 1'b0;
                    off_cnt = regs.off_deb;
                end
            end else begin
                rpt.cls   = CLS_DEADBAND;
                stuck_cnt = regs.stuck_deb;
            end
            last_peak = peak;
            rpt.level = level;
            rpt.peak  = peak;
            expected_reports.push_back(rpt);
        end
    endtask

    // compare one outgoing report with the oldest expected one
    task automatic check_report();
        t_report exp_rpt;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, level %0d peak %0d class %0d",
                     $time, i_sound_present, i_window_peak, i_window_class);
            fails++;
        end else begin
            exp_rpt = expected_reports.pop_front();
            windows++;
            if (i_sound_present !== exp_rpt.level) begin
                $display("%0t: sound_present expected %0d, got %0d",
                         $time, exp_rpt.level, i_sound_present);
                fails++;
            end
            if (i_window_peak !== exp_rpt.peak) begin
                $display("%0t: window_peak expected %0d, got %0d",
                         $time, exp_rpt.peak, i_window_peak);
                fails++;
            end
            if (i_window_class !== exp_rpt.cls) begin
                $display("%0t: window_class expected %0d, got %0d",
                         $time, exp_rpt.cls, i_window_class);
                fails++;
            end
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_out_valid && !i_out_stall) check_report();
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) take_pair(i_sample_a, i_sample_b);
        end
        o_pending <= expected_reports.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the audio presence detector: a directed pass over the class
// boundaries and register corner cases, then random sample streams under
// many register settings and idle patterns. The checker beside the block
// predicts and compares every window report.
// ----------------------------------------------------------------------------
module testbench;
    import apd_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic [SB-1:0]          sample_a = '0;
    logic [SB-1:0]          sample_b = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    wire                    in_stall;
    wire                    out_valid;
    wire                    sound_present;
    wire [SB-1:0]           window_peak;
    wire [1:0]              window_class;
    wire                    cfg_ready;

    int fail_count;
    int pending;
    int windows_checked;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pairs_sent = 0;
    int settings_used = 0;
    int quiet_set = RST_QUIET_THR;
    int loud_set = RST_LOUD_THR;
    int amp = 0;
    bit tone = 1'b0;

    audio_presence_detector #(
        .SAMPLE_BITS(SB)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_sample_a     (sample_a),
        .i_sample_b     (sample_b),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sound_present(sound_present),
        .o_window_peak  (window_peak),
        .o_window_class (window_class),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    apd_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_sample_a       (sample_a),
        .i_sample_b       (sample_b),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_sound_present  (sound_present),
        .i_window_peak    (window_peak),
        .i_window_class   (window_class),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_windows_checked(windows_checked)
    );

    always #4 clk = ~clk;

    // result side back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // hard stop
    initial begin
        #1ms;
        $display("timeout with %0d reports outstanding", pending);
        $display("** audio_presence_detector: FAILED **");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    // one sample pair, with random idle cycles ahead of it
    task automatic send_pair(input int a, input int b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_a <= a[SB-1:0];
        sample_b <= b[SB-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pairs_sent++;
    endtask

    // hold the sender until every expected report has left
    task automatic wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // also let a pair that closes no window clear the pipeline
    task automatic drain();
        wait_empty();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // full register set; leaves the write channel idle
    task automatic program_regs(input int q, input int l, input int tol, input int off_d,
                                input int on_d, input int stk_d, input int win);
        write_reg(REG_QUIET_THR, q);
        write_reg(REG_LOUD_THR, l);
        write_reg(REG_CHANGE_TOL, tol);
        write_reg(REG_OFF_DEB, off_d);
        write_reg(REG_ON_DEB, on_d);
        write_reg(REG_STUCK_DEB, stk_d);
        write_reg(REG_WINDOW_LEN, win);
        cfg_valid <= 1'b0;
        @(posedge clk);
        quiet_set = q & 12'hFFF;
        loud_set  = l & 12'hFFF;
        settings_used++;
    endtask

    // new signal level: below or near the quiet threshold, near the loud one, random, full scale or kept
    task automatic pick_amplitude();
        case ($urandom_range(5))
            0: amp = $urandom_range(quiet_set);
            1: amp = quiet_set - 3 + $urandom_range(6);
            2: amp = loud_set - 3 + $urandom_range(6);
            3: amp = $urandom_range(4095);
            4: amp = 4095;
            default: ;
        endcase
        if (amp < 0) amp = 0;
        if (amp > 4095) amp = 4095;
        tone = $urandom_range(1);
    endtask

    // steady tone with a little jitter, or noise up to the level
    function automatic int next_sample();
        int s;
        if (tone) begin
            s = amp - $urandom_range(1);
            if (s < 0) s = 0;
        end else begin
            s = $urandom_range(amp);
        end
        return s;
    endfunction

    task automatic run_random(input int n, input bit pause_midway);
        int a;
        int b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(11) == 0) pick_amplitude();
            a = next_sample();
            b = ($urandom_range(3) == 0) ? 0 : next_sample();
            send_pair(a, b);
            if (pause_midway && i == n / 2) wait_empty();
        end
    endtask

    // stream that keeps every window peak away from zero
    task automatic run_nonzero(input int n, input int top);
        for (int i = 0; i < n; i++) begin
            send_pair($urandom_range(top, 1), $urandom_range(top, 1));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one full window of 256 pairs and a partial one
        set_idling(0);
        pick_amplitude();
        run_random(260, 1'b0);
        drain();

        // class boundaries, one pair per window
        program_regs(100, 200, 10, 2, 2, 2, 1);
        send_pair(0, 0);
        send_pair(4095, 0);
        send_pair(0, 4095);
        send_pair(4095, 4095);
        send_pair(300, 1);
        send_pair(1000, 5);
        send_pair(150, 150);
        send_pair(100, 0);
        send_pair(200, 0);
        send_pair(201, 0);
        send_pair(99, 0);
        send_pair(0, 99);
        send_pair(12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA);
        drain();

        // overlapping thresholds, zero tolerance, masked and unused writes
        program_regs(300, 100, 0, 16'hF0FF, 2, 2, 1);
        write_reg(REG_STUCK_DEB, 16'hFF01);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_pair(200, 0);
        send_pair(200, 200);
        send_pair(199, 200);
        send_pair(50, 0);
        send_pair(0, 0);
        send_pair(4095, 4095);
        send_pair(4095, 4094);
        drain();

        // random settings, extremes first
        for (int ph = 0; ph < 8; ph++) begin
            set_idling(ph % 4);
            case (ph)
                0: program_regs(0, 4095, 4095, 255, 255, 255, 0);
                1: program_regs(4095, 0, 0, 1, 1, 1, 2);
                2: program_regs(4095, 4095, 1, 1, 2, 1, 3);
                default: program_regs($urandom_range(400), $urandom_range(500),
                                      $urandom_range(40), $urandom_range(1, 6),
                                      $urandom_range(1, 6), $urandom_range(1, 6),
                                      $urandom_range(1, 8));
            endcase
            pick_amplitude();
            run_random(30, ph == 2);
            drain();
        end

        // zero on debounce wraps: quiet windows load it, then 258 loud ones
        set_idling(1);
        program_regs(4095, 4095, 0, 5, 0, 5, 1);
        run_nonzero(2, 4094);
        drain();
        set_idling(3);
        program_regs(0, 0, 0, 5, 0, 5, 1);
        run_nonzero(258, 4095);
        drain();

        repeat (8) @(posedge clk);
        $display("run covered %0d sample pairs under %0d register settings",
                 pairs_sent, settings_used);
        $display("%0d window reports checked, %0d mismatches",
                 windows_checked, fail_count);
        if (fail_count == 0) begin
            $display("** audio_presence_detector: PASSED **");
        end else begin
            $display("** audio_presence_detector: FAILED **");
        end
        $finish;
    end

endmodule

// ===== audio_presence_detector.f =====
sv/apd_pkg.sv
sv/apd_window.sv
sv/apd_debounce.sv
sv/audio_presence_detector.sv
test/apd_checker.sv
test/testbench.sv
